// ----- rtl/gzhs_pkg.sv -----
// Shared types, constants and helpers for the gzip header stripper.
package gzhs_pkg;

  localparam int COUNT_BITS = 24;  // header byte counter width, 16..32
  localparam int LEN_W      = 24;  // width of the reported header length
  localparam int WIDE_W     = 33;  // holds any count and the length limit

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [7:0] FL_HCRC        = 8'h02;
  localparam logic [7:0] FL_EXTRA       = 8'h04;
  localparam logic [7:0] FL_NAME        = 8'h08;
  localparam logic [7:0] FL_COMMENT     = 8'h10;
  localparam logic [7:0] FL_RESERVED    = 8'he0;
  localparam logic [7:0] METHOD_DEFLATE = 8'd8;

  localparam logic [3:0] IDX_METHOD = 4'd2;
  localparam logic [3:0] IDX_FLAGS  = 4'd3;
  localparam logic [3:0] FIXED_LEN  = 4'd10;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_METHOD    = 2'd1;
  localparam logic [1:0] ERR_RESERVED  = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  typedef enum logic [3:0] {
    PH_FIXED   = 4'd0,
    PH_XLEN    = 4'd1,
    PH_XSKIP   = 4'd2,
    PH_NAME    = 4'd3,
    PH_COMMENT = 4'd4,
    PH_HCRC    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_DRAIN   = 4'd7
  } phase_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       payload;
    logic [LEN_W-1:0] header_length;
    logic [1:0]       error_code;
    logic             end_mark;
  } result_t;

  // First enabled optional section at or after 'from', else payload.
  function automatic phase_t section_from(phase_t from, logic [7:0] flags);
    phase_t r;
    if (from <= PH_XLEN && (flags & FL_EXTRA) != 8'h00) begin
      r = PH_XLEN;
    end else if (from <= PH_NAME && (flags & FL_NAME) != 8'h00) begin
      r = PH_NAME;
    end else if (from <= PH_COMMENT && (flags & FL_COMMENT) != 8'h00) begin
      r = PH_COMMENT;
    end else if (from <= PH_HCRC && (flags & FL_HCRC) != 8'h00) begin
      r = PH_HCRC;
    end else begin
      r = PH_PAYLOAD;
    end
    return r;
  endfunction

endpackage

// ----- rtl/gzhs_parse.sv -----
// Header walker: per-stream state and the per-byte result decision.
module gzhs_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              has_result,
  output gzhs_pkg::result_t result
);
  import gzhs_pkg::*;

  phase_t                phase, phase_next;
  logic [3:0]            fixed_index, fixed_index_next;
  logic [7:0]            flag_bits, flag_bits_next;
  logic [15:0]           extra_remaining, extra_remaining_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FIXED;
      fixed_index     <= '0;
      flag_bits       <= '0;
      extra_remaining <= '0;
      byte_count      <= '0;
    end else if (step) begin
      phase           <= phase_next;
      fixed_index     <= fixed_index_next;
      flag_bits       <= flag_bits_next;
      extra_remaining <= extra_remaining_next;
      byte_count      <= byte_count_next;
    end
  end

  always_comb begin
    logic [1:0]        err;
    logic              fresh;
    logic [WIDE_W-1:0] wide_count;

    phase_next           = phase;
    fixed_index_next     = fixed_index;
    flag_bits_next       = flag_bits;
    extra_remaining_next = extra_remaining;
    byte_count_next      = byte_count;
    err                  = ERR_NONE;
    fresh                = 1'b0;
    has_result           = 1'b0;
    result               = '0;
    wide_count           = '0;

    case (phase)
      PH_PAYLOAD: begin
        has_result      = 1'b1;
        result.kind     = KIND_PAYLOAD;
        result.payload  = data_byte;
        result.end_mark = last_byte;
        fresh           = last_byte;
      end
      PH_FIXED, PH_XLEN, PH_XSKIP, PH_NAME, PH_COMMENT, PH_HCRC: begin
        if (!(&byte_count)) begin
          byte_count_next = byte_count + 1'b1;
        end
        case (phase)
          PH_FIXED: begin
            if (fixed_index == IDX_METHOD && data_byte != METHOD_DEFLATE) begin
              err = ERR_METHOD;
            end
            if (fixed_index == IDX_FLAGS) begin
              flag_bits_next = data_byte;
              if ((data_byte & FL_RESERVED) != 8'h00) begin
                err = ERR_RESERVED;
              end
            end
            fixed_index_next = fixed_index + 1'b1;
            if (fixed_index_next >= FIXED_LEN) begin
              fixed_index_next = '0;
              phase_next       = section_from(PH_XLEN, flag_bits);
            end
          end
          PH_XLEN: begin
            if (fixed_index == 4'd0) begin
              extra_remaining_next = {8'h00, data_byte};
              fixed_index_next     = 4'd1;
            end else begin
              extra_remaining_next = {data_byte, extra_remaining[7:0]};
              fixed_index_next     = '0;
              phase_next = (extra_remaining_next != 16'h0000) ? PH_XSKIP
                                                              : section_from(PH_NAME, flag_bits);
            end
          end
          PH_XSKIP: begin
            extra_remaining_next = extra_remaining - 1'b1;
            if (extra_remaining_next == 16'h0000) begin
              phase_next = section_from(PH_NAME, flag_bits);
            end
          end
          PH_NAME: begin
            if (data_byte == 8'h00) phase_next = section_from(PH_COMMENT, flag_bits);
          end
          PH_COMMENT: begin
            if (data_byte == 8'h00) phase_next = section_from(PH_HCRC, flag_bits);
          end
          default: begin  // header CRC, two bytes
            if (fixed_index == 4'd0) begin
              fixed_index_next = 4'd1;
            end else begin
              fixed_index_next = '0;
              phase_next       = PH_PAYLOAD;
            end
          end
        endcase

        if (err != ERR_NONE) begin
          has_result        = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = err;
          result.end_mark   = last_byte;
          fresh             = last_byte;
          if (!last_byte) phase_next = PH_DRAIN;
        end else if (last_byte) begin
          // stream ended inside the header, the final header byte included
          has_result        = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_TRUNCATED;
          result.end_mark   = 1'b1;
          fresh             = 1'b1;
        end else if (phase_next == PH_PAYLOAD) begin
          wide_count           = WIDE_W'(byte_count_next);
          has_result           = 1'b1;
          result.kind          = KIND_HEADER;
          result.header_length = (wide_count > WIDE_W'(LEN_MAX)) ? LEN_MAX
                                                                 : wide_count[LEN_W-1:0];
        end
      end
      default: begin  // drain after an error: swallow up to the final byte
        if (last_byte) fresh = 1'b1;
        else phase_next = PH_DRAIN;
      end
    endcase

    if (fresh) begin
      phase_next           = PH_FIXED;
      fixed_index_next     = '0;
      flag_bits_next       = '0;
      extra_remaining_next = '0;
      byte_count_next      = '0;
    end
  end

endmodule

// ----- rtl/gzhs_result_reg.sv -----
// Output register holding one result transaction until it is taken.
module gzhs_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              load_valid,
  input  gzhs_pkg::result_t load_data,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output gzhs_pkg::result_t out_data
);
  import gzhs_pkg::*;

  // a slot being taken this cycle can be refilled in the same cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule

// ----- rtl/gzhs_pkg_unused_guard.sv -----
// Input register stage: captures one byte transaction ahead of the parser.
module gzhs_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       consume,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);
  import gzhs_pkg::*;

  assign in_ready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= data_byte;
      held_last <= last_byte;
    end
  end

endmodule

// ----- rtl/gzip_header_stripper_core.sv -----
// Top level of the gzip header stripper: input stage, parser, result register.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  input   | in_valid, in_ready  | data_byte, last_byte
//  output  | out_valid, out_ready| kind, payload, header_length, error_code, end_mark
//
// One byte per cycle sustained while the output is not stalled: a byte waits in the input register,
// and the parser decides its result combinationally and loads the result register.
// A result passes through the input register and then the result register before it is presented.
// Synchronous reset returns the parser to the start of a fresh stream.
// A stalled output holds the input register; both stages refill as they drain.
module gzip_header_stripper_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  kind,
  output logic [7:0]                  payload,
  output logic [gzhs_pkg::LEN_W-1:0]  header_length,
  output logic [1:0]                  error_code,
  output logic                        end_mark
);
  import gzhs_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic       slot_free;
  logic       step;
  logic       has_result;
  result_t    result;
  result_t    out_data;

  assign step = held_valid && slot_free;

  gzhs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .consume    (step),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  gzhs_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (held_byte),
    .last_byte  (held_last),
    .has_result (has_result),
    .result     (result)
  );

  gzhs_result_reg u_result_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .load_valid (has_result),
    .load_data  (result),
    .free       (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign kind          = out_data.kind;
  assign payload       = out_data.payload;
  assign header_length = out_data.header_length;
  assign error_code    = out_data.error_code;
  assign end_mark      = out_data.end_mark;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for gzip_header_stripper_core: directed table, then random streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gzhs_pkg::*;

  localparam int RANDOM_BYTES = 1750;
  localparam int DIR_ROWS     = 24;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [7:0]           data_byte = 8'h00;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           kind;
  logic [7:0]           payload;
  logic [LEN_W-1:0]     header_length;
  logic [1:0]           error_code;
  logic                 end_mark;

  result_t              expected_results[$];
  logic [8:0]           stream_bytes[$];   // {last, data}
  int                   mismatches = 0;
  logic                 no_gaps = 1'b0;

  // parser state mirror
  phase_t               hdr_phase;
  logic [3:0]           hdr_index;
  logic [7:0]           hdr_flags;
  logic [15:0]          extra_left;
  logic [COUNT_BITS-1:0] hdr_count;

  // Rows with typed = 1 carry an expectation read straight off the format.
  stim_row_t dir_table [DIR_ROWS] = '{
    // minimal header, no optional sections, two payload bytes
    '{8'h1f, 1'b0, 1'b0, result_t'('0)},
    '{8'h8b, 1'b0, 1'b0, result_t'('0)},
    '{8'h08, 1'b0, 1'b0, result_t'('0)},
    '{8'h00, 1'b0, 1'b0, result_t'('0)},
    '{8'h00, 1'b0, 1'b0, result_t'('0)},
    '{8'hff, 1'b0, 1'b0, result_t'('0)},
    '{8'h00, 1'b0, 1'b0, result_t'('0)},
    '{8'h00, 1'b0, 1'b0, result_t'('0)},
    '{8'h00, 1'b0, 1'b0, result_t'('0)},
    '{8'h03, 1'b0, 1'b1, {KIND_HEADER, 8'h00, 24'd10, ERR_NONE, 1'b0}},
    '{8'hff, 1'b0, 1'b1, {KIND_PAYLOAD, 8'hff, 24'd0, ERR_NONE, 1'b0}},
    '{8'h00, 1'b1, 1'b1, {KIND_PAYLOAD, 8'h00, 24'd0, ERR_NONE, 1'b1}},
    // bad method mid-stream, rest drained silently
    '{8'h1f, 1'b0, 1'b0, result_t'('0)},
    '{8'h8b, 1'b0, 1'b0, result_t'('0)},
    '{8'h07, 1'b0, 1'b1, {KIND_ERROR, 8'h00, 24'd0, ERR_METHOD, 1'b0}},
    '{8'hff, 1'b1, 1'b0, result_t'('0)},
    // reserved flags on the final byte
    '{8'h1f, 1'b0, 1'b0, result_t'('0)},
    '{8'h8b, 1'b0, 1'b0, result_t'('0)},
    '{8'h08, 1'b0, 1'b0, result_t'('0)},
    '{8'he0, 1'b1, 1'b1, {KIND_ERROR, 8'h00, 24'd0, ERR_RESERVED, 1'b1}},
    // one-byte stream is truncated
    '{8'h00, 1'b1, 1'b1, {KIND_ERROR, 8'h00, 24'd0, ERR_TRUNCATED, 1'b1}},
    // method error wins over truncation on the same byte
    '{8'h1f, 1'b0, 1'b0, result_t'('0)},
    '{8'h8b, 1'b0, 1'b0, result_t'('0)},
    '{8'h00, 1'b1, 1'b1, {KIND_ERROR, 8'h00, 24'd0, ERR_METHOD, 1'b1}}
  };

  gzip_header_stripper_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .payload       (payload),
    .header_length (header_length),
    .error_code    (error_code),
    .end_mark      (end_mark)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic restart_stream();
    hdr_phase  = PH_FIXED;
    hdr_index  = 4'd0;
    hdr_flags  = 8'h00;
    extra_left = 16'h0000;
    hdr_count  = '0;
  endtask

  // Next optional header section enabled by the flags, searching from 'start'.
  function automatic phase_t next_enabled(phase_t start, logic [7:0] f);
    phase_t nxt;
    nxt = PH_PAYLOAD;
    if (start <= PH_HCRC && (f & FL_HCRC) != 8'h00) nxt = PH_HCRC;
    if (start <= PH_COMMENT && (f & FL_COMMENT) != 8'h00) nxt = PH_COMMENT;
    if (start <= PH_NAME && (f & FL_NAME) != 8'h00) nxt = PH_NAME;
    if (start <= PH_XLEN && (f & FL_EXTRA) != 8'h00) nxt = PH_XLEN;
    return nxt;
  endfunction

  task automatic parse_gzip_byte(input logic [7:0] b, input logic lst,
                                 output logic got, output result_t r);
    logic [1:0]        err;
    logic [WIDE_W-1:0] wide;
    got = 1'b0;
    r   = '0;
    err = ERR_NONE;
    if (hdr_phase == PH_PAYLOAD) begin
      got        = 1'b1;
      r.kind     = KIND_PAYLOAD;
      r.payload  = b;
      r.end_mark = lst;
      if (lst) restart_stream();
    end else if (hdr_phase == PH_DRAIN) begin
      if (lst) restart_stream();
    end else begin
      if (hdr_count != '1) hdr_count = hdr_count + 1'b1;
      case (hdr_phase)
        PH_FIXED: begin
          if (hdr_index == IDX_METHOD && b != METHOD_DEFLATE) err = ERR_METHOD;
          if (hdr_index == IDX_FLAGS) begin
            hdr_flags = b;
            if ((b & FL_RESERVED) != 8'h00) err = ERR_RESERVED;
          end
          hdr_index = hdr_index + 1'b1;
          if (hdr_index >= FIXED_LEN) begin
            hdr_index = 4'd0;
            hdr_phase = next_enabled(PH_XLEN, hdr_flags);
          end
        end
        PH_XLEN: begin
          if (hdr_index == 4'd0) begin
            extra_left = {8'h00, b};
            hdr_index  = 4'd1;
          end else begin
            extra_left = {b, extra_left[7:0]};
            hdr_index  = 4'd0;
            hdr_phase  = (extra_left != 16'h0000) ? PH_XSKIP
                                                  : next_enabled(PH_NAME, hdr_flags);
          end
        end
        PH_XSKIP: begin
          extra_left = extra_left - 1'b1;
          if (extra_left == 16'h0000) hdr_phase = next_enabled(PH_NAME, hdr_flags);
        end
        PH_NAME: begin
          if (b == 8'h00) hdr_phase = next_enabled(PH_COMMENT, hdr_flags);
        end
        PH_COMMENT: begin
          if (b == 8'h00) hdr_phase = next_enabled(PH_HCRC, hdr_flags);
        end
        default: begin
          if (hdr_index == 4'd0) begin
            hdr_index = 4'd1;
          end else begin
            hdr_index = 4'd0;
            hdr_phase = PH_PAYLOAD;
          end
        end
      endcase
      if (err != ERR_NONE) begin
        got          = 1'b1;
        r.kind       = KIND_ERROR;
        r.error_code = err;
        r.end_mark   = lst;
        if (lst) restart_stream();
        else hdr_phase = PH_DRAIN;
      end else if (lst) begin
        got          = 1'b1;
        r.kind       = KIND_ERROR;
        r.error_code = ERR_TRUNCATED;
        r.end_mark   = 1'b1;
        restart_stream();
      end else if (hdr_phase == PH_PAYLOAD) begin
        wide            = WIDE_W'(hdr_count);
        got             = 1'b1;
        r.kind          = KIND_HEADER;
        r.header_length = (wide > WIDE_W'(LEN_MAX)) ? LEN_MAX : wide[LEN_W-1:0];
      end
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lst,
                           input logic typed, input result_t want);
    int      gap;
    logic    got;
    result_t r;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_gzip_byte(b, lst, got, r);
    if (typed) expected_results.push_back(want);
    else if (got) expected_results.push_back(r);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // zero-terminated text field with a few nonzero characters
  task automatic push_text();
    int n;
    n = $urandom_range(0, 6);
    repeat (n) stream_bytes.push_back({1'b0, 8'($urandom_range(1, 255))});
    stream_bytes.push_back(9'h000);
  endtask

  // Mostly well-formed members; some with bad method, reserved flags,
  // an early cut, or plain noise.
  task automatic build_stream();
    int          pick, n, cut;
    logic [7:0]  method, flg;
    logic [15:0] xlen;
    logic [8:0]  tail;
    pick = $urandom_range(0, 99);
    stream_bytes = {};
    if (pick >= 94) begin
      n = $urandom_range(1, 20);
      repeat (n) stream_bytes.push_back({1'b0, 8'($urandom)});
    end else begin
      stream_bytes.push_back({1'b0, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h1f});
      stream_bytes.push_back({1'b0, 8'h8b});
      method = METHOD_DEFLATE;
      if (pick < 6) begin
        method = 8'($urandom_range(0, 254));
        if (method >= METHOD_DEFLATE) method = method + 1'b1;
      end
      stream_bytes.push_back({1'b0, method});
      flg = 8'($urandom) & (FL_HCRC | FL_EXTRA | FL_NAME | FL_COMMENT | 8'h01);
      if (pick >= 6 && pick < 12) flg = flg | (8'($urandom_range(1, 7)) << 5);
      stream_bytes.push_back({1'b0, flg});
      repeat (6) stream_bytes.push_back({1'b0, 8'($urandom)});
      if ((flg & FL_EXTRA) != 8'h00) begin
        n = $urandom_range(0, 29);
        if (n == 0) xlen = 16'($urandom_range(256, 700));
        else if (n < 6) xlen = 16'h0000;
        else xlen = 16'($urandom_range(1, 8));
        stream_bytes.push_back({1'b0, xlen[7:0]});
        stream_bytes.push_back({1'b0, xlen[15:8]});
        repeat (int'(xlen)) stream_bytes.push_back({1'b0, 8'($urandom)});
      end
      if ((flg & FL_NAME) != 8'h00) push_text();
      if ((flg & FL_COMMENT) != 8'h00) push_text();
      if ((flg & FL_HCRC) != 8'h00) repeat (2) stream_bytes.push_back({1'b0, 8'($urandom)});
      // no payload means the stream ends on its last header byte
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 16);
      repeat (n) stream_bytes.push_back({1'b0, 8'($urandom)});
      if (pick >= 12 && pick < 22) begin
        cut = $urandom_range(1, stream_bytes.size());
        while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
      end
    end
    tail = stream_bytes.pop_back();
    stream_bytes.push_back({1'b1, tail[7:0]});
  endtask

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual kind %0d payload 0x%0h",
                 $time, kind, payload);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, kind);
        check_field("payload", want.payload, payload);
        check_field("header_length", want.header_length, header_length);
        check_field("error_code", want.error_code, error_code);
        check_field("end_mark", want.end_mark, end_mark);
      end
    end
  end

  // Receiver: stretches of steady ready alternate with random stalls.
  initial begin : drive_ready
    int   stall, stretch;
    logic steady;
    stall = 0;
    forever begin
      stretch = $urandom_range(20, 300);
      steady  = ($urandom_range(0, 4) == 0);
      repeat (stretch) begin
        @(negedge clk);
        if (steady) begin
          out_ready <= 1'b1;
        end else if (stall != 0) begin
          stall--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) < 7) begin
          out_ready <= 1'b1;
        end else begin
          stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin : drive_stream
    int bytes_sent;
    bytes_sent = 0;
    restart_stream();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      send_byte(dir_table[i].data, dir_table[i].last, dir_table[i].typed, dir_table[i].want);
    end
    hold_until_drained();

    while (bytes_sent < RANDOM_BYTES) begin
      build_stream();
      no_gaps = ($urandom_range(0, 3) == 0);
      foreach (stream_bytes[i]) begin
        send_byte(stream_bytes[i][7:0], stream_bytes[i][8], 1'b0, result_t'('0));
      end
      bytes_sent += stream_bytes.size();
      if ($urandom_range(0, 14) == 0) hold_until_drained();
    end

    hold_until_drained();
    // let any stray result surface before judging
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
